[hw/rtl/bsogw_pkg.sv]
// Shared types and constants of the biased second-order graph walker.
package bsogw_pkg;

  localparam int unsigned NodeW   = 16;
  localparam int unsigned WeightW = 17;
  localparam int unsigned InvW    = 16;
  localparam int unsigned DrawW   = 16;
  localparam int unsigned RowW    = 19;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned ScaledW = 25;

  typedef logic [1:0] func_t;
  localparam func_t FuncLoadRow  = 2'd0;
  localparam func_t FuncLoadEdge = 2'd1;
  localparam func_t FuncStart    = 2'd2;
  localparam func_t FuncStep     = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegWalkLength    = 2'd0;
  localparam reg_idx_t RegInvReturnBias = 2'd1;
  localparam reg_idx_t RegInvInoutBias  = 2'd2;

  typedef logic [1:0] rp_sel_t;
  localparam rp_sel_t RpCur      = 2'd0;
  localparam rp_sel_t RpCurNext  = 2'd1;
  localparam rp_sel_t RpPrev     = 2'd2;
  localparam rp_sel_t RpPrevNext = 2'd3;

  typedef logic [1:0] wsrc_t;
  localparam wsrc_t WRaw    = 2'd0;
  localparam wsrc_t WReturn = 2'd1;
  localparam wsrc_t WInout  = 2'd2;

  typedef logic [1:0] res_src_t;
  localparam res_src_t ResCand  = 2'd0;
  localparam res_src_t ResFirst = 2'd1;
  localparam res_src_t ResCur   = 2'd2;

  typedef struct packed {
    logic [NodeW-1:0]   node;
    logic [WeightW-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic     accept;
    logic     wr_rp;
    logic     wr_edge;
    logic     start;
    logic     rp_rd;
    rp_sel_t  rp_sel;
    logic     cap_lo;
    logic     cap_hi;
    logic     pair_prev;
    logic     edge_rd;
    logic     edge_k;
    logic     cap_edge;
    logic     wload;
    wsrc_t    wsrc;
    logic     w_mem;
    logic     k_init;
    logic     k_inc;
    logic     z_init;
    logic     z_inc;
    logic     acc_clr;
    logic     acc;
    logic     tgt_raw;
    logic     mul_init;
    logic     mul_step;
    logic     res_load;
    res_src_t res_src;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic step0;
    logic empty;
    logic cand_prev;
    logic k_empty;
    logic k_match;
    logic k_last;
    logic z_last;
    logic hit;
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/bsogw_ctrl.sv]
// Controller state machine that sequences loads, walk starts and step sampling.
module bsogw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bsogw_pkg::func_t   func_i,
  input  bsogw_pkg::status_t status_i,
  output logic               in_ready_o,
  output bsogw_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RC0  = 4'd1;
  localparam logic [3:0] S_RC1  = 4'd2;
  localparam logic [3:0] S_RC2  = 4'd3;
  localparam logic [3:0] S_RP0  = 4'd4;
  localparam logic [3:0] S_RP1  = 4'd5;
  localparam logic [3:0] S_RP2  = 4'd6;
  localparam logic [3:0] S_BEG  = 4'd7;
  localparam logic [3:0] S_ZRD  = 4'd8;
  localparam logic [3:0] S_ZCAP = 4'd9;
  localparam logic [3:0] S_KRD  = 4'd10;
  localparam logic [3:0] S_KCMP = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;
  localparam logic [3:0] S_CHK  = 4'd13;
  localparam logic [3:0] S_TMUL = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          cmd_o.accept = 1'b1;
          unique case (func_i)
            bsogw_pkg::FuncLoadRow:  cmd_o.wr_rp = 1'b1;
            bsogw_pkg::FuncLoadEdge: cmd_o.wr_edge = 1'b1;
            bsogw_pkg::FuncStart:    cmd_o.start = 1'b1;
            bsogw_pkg::FuncStep: begin
              if (status_i.active) state_d = S_RC0;
            end
            default: ;
          endcase
        end
      end
      S_RC0: begin
        cmd_o.rp_rd  = 1'b1;
        cmd_o.rp_sel = bsogw_pkg::RpCur;
        state_d      = S_RC1;
      end
      S_RC1: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.rp_rd  = 1'b1;
        cmd_o.rp_sel = bsogw_pkg::RpCurNext;
        state_d      = S_RC2;
      end
      S_RC2: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = status_i.step0 ? S_BEG : S_RP0;
      end
      S_RP0: begin
        cmd_o.rp_rd  = 1'b1;
        cmd_o.rp_sel = bsogw_pkg::RpPrev;
        state_d      = S_RP1;
      end
      S_RP1: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.rp_rd  = 1'b1;
        cmd_o.rp_sel = bsogw_pkg::RpPrevNext;
        state_d      = S_RP2;
      end
      S_RP2: begin
        cmd_o.cap_hi    = 1'b1;
        cmd_o.pair_prev = 1'b1;
        state_d         = S_BEG;
      end
      S_BEG: begin
        if (status_i.empty) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = bsogw_pkg::ResCur;
          state_d        = S_FIN;
        end else begin
          cmd_o.z_init  = 1'b1;
          cmd_o.acc_clr = 1'b1;
          cmd_o.tgt_raw = status_i.step0;
          pass_d        = status_i.step0;
          state_d       = S_ZRD;
        end
      end
      S_ZRD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = S_ZCAP;
      end
      S_ZCAP: begin
        cmd_o.cap_edge = 1'b1;
        cmd_o.w_mem    = 1'b1;
        if (status_i.step0) begin
          cmd_o.wload = 1'b1;
          cmd_o.wsrc  = bsogw_pkg::WRaw;
          state_d     = S_ACC;
        end else if (status_i.cand_prev) begin
          cmd_o.wload = 1'b1;
          cmd_o.wsrc  = bsogw_pkg::WReturn;
          state_d     = S_ACC;
        end else if (status_i.k_empty) begin
          cmd_o.wload = 1'b1;
          cmd_o.wsrc  = bsogw_pkg::WInout;
          state_d     = S_ACC;
        end else begin
          cmd_o.k_init = 1'b1;
          state_d      = S_KRD;
        end
      end
      S_KRD: begin
        cmd_o.edge_rd = 1'b1;
        cmd_o.edge_k  = 1'b1;
        state_d       = S_KCMP;
      end
      S_KCMP: begin
        if (status_i.k_match) begin
          cmd_o.wload = 1'b1;
          cmd_o.wsrc  = bsogw_pkg::WRaw;
          state_d     = S_ACC;
        end else if (status_i.k_last) begin
          cmd_o.wload = 1'b1;
          cmd_o.wsrc  = bsogw_pkg::WInout;
          state_d     = S_ACC;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = S_KRD;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (pass_q && status_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = bsogw_pkg::ResCand;
          state_d        = S_FIN;
        end else if (status_i.z_last) begin
          if (pass_q) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_src  = bsogw_pkg::ResFirst;
            state_d        = S_FIN;
          end else begin
            cmd_o.mul_init = 1'b1;
            state_d        = S_TMUL;
          end
        end else begin
          cmd_o.z_inc = 1'b1;
          state_d     = S_ZRD;
        end
      end
      S_TMUL: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_done) begin
          cmd_o.z_init  = 1'b1;
          cmd_o.acc_clr = 1'b1;
          pass_d        = 1'b1;
          state_d       = S_ZRD;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/bsogw_dp.sv]
// Datapath with graph tables, walk state, weight scaling, sums and result register.
module bsogw_dp #(
  parameter int unsigned MAX_NODES = 65536,
  parameter int unsigned MAX_EDGES = 262144
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsogw_pkg::cmd_t                   cmd_i,
  output bsogw_pkg::status_t                status_o,
  input  logic                              cfg_we_i,
  input  bsogw_pkg::reg_idx_t               cfg_index_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic [bsogw_pkg::AddrW-1:0]       table_address_i,
  input  logic [bsogw_pkg::RowW-1:0]        row_offset_i,
  input  logic [bsogw_pkg::NodeW-1:0]       neighbor_node_i,
  input  logic [bsogw_pkg::WeightW-1:0]     edge_weight_i,
  input  logic [bsogw_pkg::NodeW-1:0]       start_node_i,
  input  logic [bsogw_pkg::DrawW-1:0]       draw_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [bsogw_pkg::NodeW-1:0]       walk_node_o,
  output logic [15:0]                       position_o,
  output logic                              last_of_walk_o
);

  localparam int unsigned NAW = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ZW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned CW  = EAW + bsogw_pkg::ScaledW;
  localparam int unsigned TW  = CW + bsogw_pkg::DrawW;
  localparam int unsigned NW  = bsogw_pkg::NodeW;

  logic [bsogw_pkg::RowW-1:0] rp_mem [MAX_NODES+1];
  bsogw_pkg::edge_t           edge_mem [MAX_EDGES];

  logic [15:0] walk_length_q, inv_ret_q, inv_io_q;
  logic [NW-1:0] cur_q, prev_q, res_q, cand_q, first_q;
  logic [15:0] step_q;
  logic        active_q;
  logic [bsogw_pkg::DrawW-1:0] draw_q;
  logic [bsogw_pkg::RowW-1:0] rp_rdata_q, lo_raw_q;
  bsogw_pkg::edge_t edge_rdata_q;
  logic [ZW-1:0] lo_q, hi_q, plo_q, phi_q, z_q, k_q;
  logic [bsogw_pkg::WeightW-1:0] w_q;
  logic [bsogw_pkg::ScaledW-1:0] weight_q, weight_d;
  logic [CW-1:0] cum_q;
  logic [TW-1:0] tgt_q, mcand_q;
  logic [bsogw_pkg::DrawW-1:0] mplier_q;
  logic [3:0] mcnt_q;
  logic out_valid_q, out_last_q;
  logic [NW-1:0] out_node_q;
  logic [15:0] out_pos_q;

  logic [31:0] addr32, rp_node32, rp_rd32, hi32, lo32;
  logic [NW-1:0] rp_node, pair_node;
  logic          rp_node_ok, pair_ok;
  logic [NAW-1:0] rp_addr;
  logic [EAW-1:0] edge_addr;
  logic [bsogw_pkg::WeightW-1:0] w_src;
  logic [15:0] inv_sel;
  logic [32:0] prod;
  logic [15:0] step_n;
  logic        last_n, out_free;
  logic [NW-1:0] res_d;

  assign addr32 = 32'(table_address_i);

  always_comb begin
    rp_node = (cmd_i.rp_sel == bsogw_pkg::RpPrev || cmd_i.rp_sel == bsogw_pkg::RpPrevNext)
              ? prev_q : cur_q;
    rp_node_ok = (32'(rp_node) + 32'd1) <= MAX_NODES;
    rp_node32 = 32'(rp_node) + 32'(cmd_i.rp_sel[0]);
    rp_addr = rp_node_ok ? rp_node32[NAW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_rp && addr32 <= MAX_NODES) begin
      rp_mem[addr32[NAW-1:0]] <= row_offset_i;
    end
    if (cmd_i.rp_rd) begin
      rp_rdata_q <= rp_mem[rp_addr];
    end
  end

  assign edge_addr = cmd_i.edge_k ? k_q[EAW-1:0] : z_q[EAW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_edge && addr32 < MAX_EDGES) begin
      edge_mem[addr32[EAW-1:0]] <= '{node: neighbor_node_i, weight: edge_weight_i};
    end
    if (cmd_i.edge_rd) begin
      edge_rdata_q <= edge_mem[edge_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_length_q <= 16'd10;
      inv_ret_q     <= 16'd256;
      inv_io_q      <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsogw_pkg::RegWalkLength:    walk_length_q <= cfg_wdata_i;
        bsogw_pkg::RegInvReturnBias: inv_ret_q <= cfg_wdata_i;
        bsogw_pkg::RegInvInoutBias:  inv_io_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pair_node = cmd_i.pair_prev ? prev_q : cur_q;
    pair_ok   = (32'(pair_node) + 32'd1) <= MAX_NODES;
    rp_rd32   = 32'(rp_rdata_q);
    hi32      = (rp_rd32 > MAX_EDGES) ? 32'(MAX_EDGES) : rp_rd32;
    lo32      = (32'(lo_raw_q) > hi32) ? hi32 : 32'(lo_raw_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) draw_q <= draw_i;
    if (cmd_i.cap_lo) lo_raw_q <= rp_rdata_q;
    if (cmd_i.cap_hi) begin
      if (cmd_i.pair_prev) begin
        plo_q <= pair_ok ? lo32[ZW-1:0] : '0;
        phi_q <= pair_ok ? hi32[ZW-1:0] : '0;
      end else begin
        lo_q <= pair_ok ? lo32[ZW-1:0] : '0;
        hi_q <= pair_ok ? hi32[ZW-1:0] : '0;
      end
    end
    if (cmd_i.z_init) z_q <= lo_q;
    else if (cmd_i.z_inc) z_q <= z_q + ZW'(1);
    if (cmd_i.k_init) k_q <= plo_q;
    else if (cmd_i.k_inc) k_q <= k_q + ZW'(1);
    if (cmd_i.cap_edge) begin
      cand_q <= edge_rdata_q.node;
      w_q    <= edge_rdata_q.weight;
      if (z_q == lo_q) first_q <= edge_rdata_q.node;
    end
    if (cmd_i.wload) weight_q <= weight_d;
    if (cmd_i.acc_clr) cum_q <= '0;
    else if (cmd_i.acc) cum_q <= cum_q + CW'(weight_q);
    if (cmd_i.tgt_raw) begin
      tgt_q <= TW'(draw_q);
    end else if (cmd_i.mul_init) begin
      tgt_q    <= '0;
      mcand_q  <= TW'(cum_q);
      mplier_q <= draw_q;
      mcnt_q   <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) tgt_q <= tgt_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      mcnt_q   <= mcnt_q + 4'd1;
    end
    if (cmd_i.res_load) res_q <= res_d;
  end

  always_comb begin
    w_src   = cmd_i.w_mem ? edge_rdata_q.weight : w_q;
    inv_sel = (cmd_i.wsrc == bsogw_pkg::WReturn) ? inv_ret_q : inv_io_q;
    prod    = {16'b0, w_src} * {17'b0, inv_sel};
    weight_d = (cmd_i.wsrc == bsogw_pkg::WRaw) ? bsogw_pkg::ScaledW'(w_src)
                                                : prod[32:8];
  end

  always_comb begin
    case (cmd_i.res_src)
      bsogw_pkg::ResCand:  res_d = cand_q;
      bsogw_pkg::ResFirst: res_d = first_q;
      default:             res_d = cur_q;
    endcase
  end

  assign step_n   = step_q + 16'd1;
  assign last_n   = (17'(step_n) + 17'd1) >= 17'(walk_length_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      prev_q      <= '0;
      step_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cur_q       <= start_node_i;
        prev_q      <= start_node_i;
        step_q      <= '0;
        active_q    <= walk_length_q > 16'd1;
        out_valid_q <= 1'b1;
      end else if (cmd_i.emit) begin
        cur_q       <= res_q;
        prev_q      <= cur_q;
        step_q      <= step_n;
        if (last_n) active_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      out_node_q <= start_node_i;
      out_pos_q  <= '0;
      out_last_q <= walk_length_q <= 16'd1;
    end else if (cmd_i.emit) begin
      out_node_q <= res_q;
      out_pos_q  <= step_n;
      out_last_q <= last_n;
    end
  end

  always_comb begin
    status_o.active    = active_q;
    status_o.step0     = step_q == 16'd0;
    status_o.empty     = lo_q >= hi_q;
    status_o.cand_prev = edge_rdata_q.node == prev_q;
    status_o.k_empty   = plo_q >= phi_q;
    status_o.k_match   = edge_rdata_q.node == cand_q;
    status_o.k_last    = (k_q + ZW'(1)) == phi_q;
    status_o.z_last    = (z_q + ZW'(1)) == hi_q;
    status_o.hit       = (step_q == 16'd0) ? (tgt_q <= TW'(cum_q))
                                           : (tgt_q <= {cum_q, 16'b0});
    status_o.mul_done  = mcnt_q == 4'd15;
    status_o.out_free  = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign walk_node_o    = out_node_q;
  assign position_o     = out_pos_q;
  assign last_of_walk_o = out_last_q;

endmodule

[hw/rtl/biased_second_order_graph_walker.sv]
// Loads and starts finish on acceptance; a start result is valid the cycle after acceptance.
// A first step scans the current node's edges once. A later step scans them twice,
// looking each candidate up in the previous node's edge list, with a shift-add multiply
// between the two scans, as the edge table is single-port.
// Reset clears the walk state and sets the registers to their defaults;
// the graph tables are not cleared and hold garbage until loaded.
module biased_second_order_graph_walker #(
  parameter int unsigned MAX_NODES = 65536,
  parameter int unsigned MAX_EDGES = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [17:0] table_address_i,
  input  logic [18:0] row_offset_i,
  input  logic [15:0] neighbor_node_i,
  input  logic [16:0] edge_weight_i,
  input  logic [15:0] start_node_i,
  input  logic [15:0] draw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] walk_node_o,
  output logic [15:0] position_o,
  output logic        last_of_walk_o
);

  bsogw_pkg::cmd_t    cmd;
  bsogw_pkg::status_t status;

  bsogw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  bsogw_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .table_address_i (table_address_i),
    .row_offset_i    (row_offset_i),
    .neighbor_node_i (neighbor_node_i),
    .edge_weight_i   (edge_weight_i),
    .start_node_i    (start_node_i),
    .draw_i          (draw_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .walk_node_o     (walk_node_o),
    .position_o      (position_o),
    .last_of_walk_o  (last_of_walk_o)
  );

endmodule
